// File: rtl/core/avr_pkg.sv
// Shared types, constants and tables of the axis vector rotation block.
package avr_pkg;

  localparam int COMP_WIDTH  = 18;
  localparam int ANGLE_WIDTH = 16;
  localparam int ITERATIONS  = 28;
  localparam int GUARD       = 16;
  localparam int GAIN_SHIFT  = 31 - GUARD;
  localparam int DATA_WIDTH  = COMP_WIDTH + GUARD + 2;
  localparam int PHASE_WIDTH = 33;
  localparam int PROD_WIDTH  = COMP_WIDTH + 32;
  localparam int IDX_WIDTH   = $clog2(ITERATIONS);

  localparam logic signed [31:0] GAIN_Q31 = 32'sd1304065748;

  localparam logic [31:0] ATAN_TAB [ITERATIONS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef enum logic [1:0] {
    CMD_X    = 2'd0,
    CMD_Y    = 2'd1,
    CMD_Z    = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  typedef struct packed {
    cmd_e                          cmd;
    logic signed [COMP_WIDTH-1:0]  pass_c;
    logic signed [COMP_WIDTH-1:0]  raw_a;
    logic signed [COMP_WIDTH-1:0]  raw_b;
    logic signed [DATA_WIDTH-1:0]  a;
    logic signed [DATA_WIDTH-1:0]  b;
    logic signed [PHASE_WIDTH-1:0] phase;
  } avr_item_t;

endpackage

// File: rtl/core/avr_gain.sv
// Input stage: pair selection, gain multiply, then quadrant rotation.
module avr_gain (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  avr_pkg::cmd_e                         cmd_i,
  input  logic [avr_pkg::ANGLE_WIDTH-1:0]       angle_i,
  input  logic signed [avr_pkg::COMP_WIDTH-1:0] x_i,
  input  logic signed [avr_pkg::COMP_WIDTH-1:0] y_i,
  input  logic signed [avr_pkg::COMP_WIDTH-1:0] z_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output avr_pkg::avr_item_t                    item_o
);
  import avr_pkg::*;

  logic signed [COMP_WIDTH-1:0] sel_a, sel_b, sel_c;
  logic [ANGLE_WIDTH-1:0]       phi;
  logic signed [PROD_WIDTH-1:0] prod_a, prod_b;
  avr_item_t                    mul_d, mul_q, rot_d, rot_q;
  quad_e                        quad_q;
  logic                         mul_valid_q, rot_valid_q;
  logic                         mul_ready, rot_ready;

  always_comb begin
    case (cmd_i)
      CMD_X: begin
        sel_a = y_i;
        sel_b = z_i;
        sel_c = x_i;
      end
      CMD_Y: begin
        sel_a = z_i;
        sel_b = x_i;
        sel_c = y_i;
      end
      default: begin
        sel_a = x_i;
        sel_b = y_i;
        sel_c = z_i;
      end
    endcase
  end

  assign phi    = {ANGLE_WIDTH{1'b0}} - angle_i;
  assign prod_a = sel_a * GAIN_Q31;
  assign prod_b = sel_b * GAIN_Q31;

  always_comb begin
    mul_d.cmd    = cmd_i;
    mul_d.pass_c = sel_c;
    mul_d.raw_a  = sel_a;
    mul_d.raw_b  = sel_b;
    mul_d.a      = DATA_WIDTH'(prod_a >>> GAIN_SHIFT);
    mul_d.b      = DATA_WIDTH'(prod_b >>> GAIN_SHIFT);
    mul_d.phase  = PHASE_WIDTH'({phi[ANGLE_WIDTH-3:0], {(32-ANGLE_WIDTH){1'b0}}});
  end

  assign rot_ready = !rot_valid_q || ready_i;
  assign mul_ready = !mul_valid_q || rot_ready;
  assign ready_o   = mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (mul_ready) begin
      mul_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready) begin
      mul_q  <= mul_d;
      quad_q <= quad_e'(phi[ANGLE_WIDTH-1:ANGLE_WIDTH-2]);
    end
  end

  always_comb begin
    rot_d = mul_q;
    case (quad_q)
      QUAD_90: begin
        rot_d.a = -mul_q.b;
        rot_d.b = mul_q.a;
      end
      QUAD_180: begin
        rot_d.a = -mul_q.a;
        rot_d.b = -mul_q.b;
      end
      QUAD_270: begin
        rot_d.a = mul_q.b;
        rot_d.b = -mul_q.a;
      end
      default: begin
        rot_d = mul_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_valid_q <= 1'b0;
    end else if (rot_ready) begin
      rot_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot_ready) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = rot_valid_q;
  assign item_o  = rot_q;

endmodule

// File: rtl/core/avr_cell.sv
// One CORDIC micro-rotation cell with its own pipeline register.
module avr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [avr_pkg::IDX_WIDTH-1:0] idx_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  avr_pkg::avr_item_t            item_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output avr_pkg::avr_item_t            item_o
);
  import avr_pkg::*;

  logic signed [DATA_WIDTH-1:0]  da, db;
  logic signed [PHASE_WIDTH-1:0] step;
  avr_item_t                     item_d, item_q;
  logic                          valid_q;

  assign da   = item_i.b >>> idx_i;
  assign db   = item_i.a >>> idx_i;
  assign step = $signed({1'b0, ATAN_TAB[idx_i]});

  always_comb begin
    item_d = item_i;
    if (!item_i.phase[PHASE_WIDTH-1]) begin
      item_d.a     = item_i.a - da;
      item_d.b     = item_i.b + db;
      item_d.phase = item_i.phase - step;
    end else begin
      item_d.a     = item_i.a + da;
      item_d.b     = item_i.b - db;
      item_d.phase = item_i.phase + step;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/core/avr_out.sv
// Output stage: rounding, saturation and axis remapping into the output register.
module avr_out (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  avr_pkg::avr_item_t                    item_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [avr_pkg::COMP_WIDTH-1:0] x_o,
  output logic signed [avr_pkg::COMP_WIDTH-1:0] y_o,
  output logic signed [avr_pkg::COMP_WIDTH-1:0] z_o
);
  import avr_pkg::*;

  localparam logic signed [DATA_WIDTH-1:0] ROUND_HALF =
    {{(DATA_WIDTH-GUARD){1'b0}}, 1'b1, {(GUARD-1){1'b0}}};

  function automatic logic [COMP_WIDTH-1:0] round_sat(input logic signed [DATA_WIDTH-1:0] v);
    logic signed [DATA_WIDTH-1:0]      sum;
    logic signed [DATA_WIDTH-1:0]      r;
    logic [DATA_WIDTH-COMP_WIDTH:0]    top;
    sum = v + ROUND_HALF;
    r   = sum >>> GUARD;
    top = r[DATA_WIDTH-1:COMP_WIDTH-1];
    if (&top || ~|top) begin
      return r[COMP_WIDTH-1:0];
    end
    return {r[DATA_WIDTH-1], {(COMP_WIDTH-1){~r[DATA_WIDTH-1]}}};
  endfunction

  logic signed [COMP_WIDTH-1:0] ra, rb;
  logic signed [COMP_WIDTH-1:0] x_d, y_d, z_d, x_q, y_q, z_q;
  logic                         valid_q;

  assign ra = round_sat(item_i.a);
  assign rb = round_sat(item_i.b);

  always_comb begin
    case (item_i.cmd)
      CMD_X: begin
        x_d = item_i.pass_c;
        y_d = ra;
        z_d = rb;
      end
      CMD_Y: begin
        x_d = rb;
        y_d = item_i.pass_c;
        z_d = ra;
      end
      CMD_Z: begin
        x_d = ra;
        y_d = rb;
        z_d = item_i.pass_c;
      end
      default: begin
        x_d = item_i.raw_a;
        y_d = item_i.raw_b;
        z_d = item_i.pass_c;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

// File: rtl/core/axis_vector_rotation.sv
// Top level of the axis vector rotation block: gain stage, CORDIC cell row, output stage.
// Pipeline: an accepted transfer passes two gain and quadrant stages, 28 CORDIC cells and
// one output register on its way to out_valid_o.
// Throughput: one vector per cycle; every stage advances when its successor is empty or moving.
// An output stall fills empty stages first; in_stall_o rises only when all 31 stages hold data.
// Reset clears all valid flags asynchronously; payload registers are not reset.
module axis_vector_rotation (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            command_i,
  input  logic [avr_pkg::ANGLE_WIDTH-1:0]       turn_angle_i,
  input  logic signed [avr_pkg::COMP_WIDTH-1:0] comp_x_in_i,
  input  logic signed [avr_pkg::COMP_WIDTH-1:0] comp_y_in_i,
  input  logic signed [avr_pkg::COMP_WIDTH-1:0] comp_z_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [avr_pkg::COMP_WIDTH-1:0] comp_x_out_o,
  output logic signed [avr_pkg::COMP_WIDTH-1:0] comp_y_out_o,
  output logic signed [avr_pkg::COMP_WIDTH-1:0] comp_z_out_o
);
  import avr_pkg::*;

  logic      in_ready;
  logic      valid_c [ITERATIONS+1];
  logic      ready_c [ITERATIONS+1];
  avr_item_t item_c  [ITERATIONS+1];

  assign in_stall_o = !in_ready;

  avr_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .cmd_i   (cmd_e'(command_i)),
    .angle_i (turn_angle_i),
    .x_i     (comp_x_in_i),
    .y_i     (comp_y_in_i),
    .z_i     (comp_z_in_i),
    .valid_o (valid_c[0]),
    .ready_i (ready_c[0]),
    .item_o  (item_c[0])
  );

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    avr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_WIDTH'(k)),
      .valid_i (valid_c[k]),
      .ready_o (ready_c[k]),
      .item_i  (item_c[k]),
      .valid_o (valid_c[k+1]),
      .ready_i (ready_c[k+1]),
      .item_o  (item_c[k+1])
    );
  end

  avr_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c[ITERATIONS]),
    .ready_o (ready_c[ITERATIONS]),
    .item_i  (item_c[ITERATIONS]),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .x_o     (comp_x_out_o),
    .y_o     (comp_y_out_o),
    .z_o     (comp_z_out_o)
  );

endmodule

// File: rtl/core/avr_checker.sv
// Port-level assertions for the axis vector rotation block and their bind.
module avr_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic [1:0]                            command_i,
  input logic [avr_pkg::ANGLE_WIDTH-1:0]       turn_angle_i,
  input logic signed [avr_pkg::COMP_WIDTH-1:0] comp_x_in_i,
  input logic signed [avr_pkg::COMP_WIDTH-1:0] comp_y_in_i,
  input logic signed [avr_pkg::COMP_WIDTH-1:0] comp_z_in_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [avr_pkg::COMP_WIDTH-1:0] comp_x_out_o,
  input logic signed [avr_pkg::COMP_WIDTH-1:0] comp_y_out_o,
  input logic signed [avr_pkg::COMP_WIDTH-1:0] comp_z_out_o
);

  a_in_stall_needs_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output side can move");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(command_i)
      && $stable(turn_angle_i) && $stable(comp_x_in_i) && $stable(comp_y_in_i)
      && $stable(comp_z_in_i)))
    else $error("stalled input transfer changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(comp_x_out_o)
      && $stable(comp_y_out_o) && $stable(comp_z_out_o)))
    else $error("stalled output transfer changed");

  a_out_drop_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("output valid dropped without a transfer");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> (!out_valid_o && !in_stall_o))
    else $error("block not idle in reset");

endmodule

bind axis_vector_rotation avr_checker u_avr_checker (.*);
